>>> rtl/core/wait_queue_signal_match_macros.svh
// Assertion macros for the wait queue block.
// Used by the port checker; no other dependencies.
`ifndef WAIT_QUEUE_SIGNAL_MATCH_MACROS_SVH
`define WAIT_QUEUE_SIGNAL_MATCH_MACROS_SVH
`define WQSM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wqsm check failed");
`define WQSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wqsm check failed");
`endif

>>> rtl/core/wqsm_pkg.sv
// Package for the wait queue block: opcodes, status codes, queue entry type.
// No dependencies.
`default_nettype none
package wqsm_pkg;
    localparam int THREAD_ID_BITS = 8;

    localparam logic [2:0] OP_PARK      = 3'd0;
    localparam logic [2:0] OP_WAKE_ONE  = 3'd1;
    localparam logic [2:0] OP_WAKE_ALL  = 3'd2;
    localparam logic [2:0] OP_WAKE_MTCH = 3'd3;
    localparam logic [2:0] OP_CLAIM     = 3'd4;

    localparam logic [2:0] ST_PARKED    = 3'd0;
    localparam logic [2:0] ST_KILLED    = 3'd1;
    localparam logic [2:0] ST_PRED      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_WAKE      = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  thread_id;
        logic [31:0] wait_mask;
        logic [31:0] signal_bits;
        logic        thread_killed;
        logic        predicate_holds;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic       woke_valid;
        logic [7:0] woken_thread;
        logic [4:0] wake_cnt;
        logic       queue_nonempty;
        logic       last_result;
    } res_t;
endpackage
`default_nettype wire

>>> rtl/core/wqsm_front.sv
// Front end: accepts input transfers into a two-entry command queue.
// Depends on wqsm_pkg.
`default_nettype none
module wqsm_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wqsm_pkg::cmd_t       in_cmd,
    output logic                 cq_valid,
    input  wire                  cq_ready,
    output wqsm_pkg::cmd_t       cq_cmd
);
    import wqsm_pkg::*;
    cmd_t       buf_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign cq_valid = (cnt_reg != 2'd0);
    assign cq_cmd   = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = cq_valid && cq_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/wqsm_back.sv
// Back end: waiter table and sequencer that scans slots and emits results.
// Depends on wqsm_pkg.
`default_nettype none
module wqsm_back #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int BATCH          = 8
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             cq_valid,
    output logic            cq_ready,
    input  wqsm_pkg::cmd_t  cq_cmd,
    output logic            res_valid,
    input  wire             res_ready,
    output wqsm_pkg::res_t  res_data
);
    import wqsm_pkg::*;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = $clog2(BATCH + 1);
    localparam int PW = (BATCH > 1) ? $clog2(BATCH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [THREAD_ID_BITS-1:0] thr_reg [QUEUE_DEPTH];
    logic [31:0]               msk_reg [QUEUE_DEPTH];
    logic [CW-1:0]             n_reg;
    logic [THREAD_ID_BITS-1:0] pick_reg [BATCH];
    logic [BW-1:0]             pc_reg;
    logic [2:0]                st_reg;
    cmd_t                      cmd_reg;
    logic [CW-1:0]             rd_reg, wr_reg, m_reg, cnt_reg, n0_reg;
    logic                      one_reg;
    res_t                      out_reg;
    logic                      ov_reg;

    logic out_free, cur_hit, cur_valid, last_batch, done_scan;
    logic [THREAD_ID_BITS-1:0] tid, cur_thr;
    logic [31:0] cur_msk;
    logic [CW-1:0] cnt_inc;
    logic [BW-1:0] pc_dec;

    assign out_free  = !ov_reg || res_ready;
    assign res_valid = ov_reg;
    assign res_data  = out_reg;
    assign cq_ready  = (st_reg == S_IDLE) && out_free;
    assign tid       = cmd_reg.thread_id[THREAD_ID_BITS-1:0];
    assign cur_valid = rd_reg < n0_reg;
    assign cur_thr   = thr_reg[rd_reg[IW-1:0]];
    assign cur_msk   = msk_reg[rd_reg[IW-1:0]];
    assign cnt_inc   = cnt_reg + CW'(1);
    assign pc_dec    = pc_reg - BW'(1);
    assign done_scan = !cur_valid || (one_reg && m_reg != '0);

    always_comb begin
        case (cmd_reg.opcode)
            OP_WAKE_ONE:  cur_hit = (cur_msk == '0);
            OP_WAKE_ALL:  cur_hit = (cur_msk == '0);
            OP_WAKE_MTCH: cur_hit = (cur_msk != '0) && ((cur_msk & cmd_reg.signal_bits) != '0);
            OP_CLAIM:     cur_hit = (cur_thr == tid);
            default:      cur_hit = 1'b0;
        endcase
    end
    assign last_batch = done_scan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            n_reg  <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (res_ready) ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (cq_valid && out_free) begin
                        cmd_reg <= cq_cmd;
                        rd_reg <= '0;
                        wr_reg <= '0;
                        m_reg <= '0;
                        cnt_reg <= '0;
                        pc_reg <= '0;
                        n0_reg <= n_reg;
                        one_reg <= (cq_cmd.opcode == OP_WAKE_ONE) ||
                                   (cq_cmd.opcode == OP_CLAIM);
                        if (cq_cmd.opcode == OP_PARK) begin
                            out_reg.woke_valid <= 1'b0;
                            out_reg.woken_thread <= '0;
                            out_reg.wake_cnt <= '0;
                            out_reg.last_result <= 1'b1;
                            ov_reg <= 1'b1;
                            out_reg.queue_nonempty <= n_reg != '0;
                            if (cq_cmd.wait_mask != '0 && cq_cmd.thread_killed) begin
                                out_reg.status <= ST_KILLED;
                            end else if (!cq_cmd.predicate_holds) begin
                                out_reg.status <= ST_PRED;
                            end else if (n_reg >= CW'(QUEUE_DEPTH)) begin
                                out_reg.status <= ST_FULL;
                            end else begin
                                out_reg.status <= ST_PARKED;
                                out_reg.queue_nonempty <= 1'b1;
                                for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
                                    thr_reg[i] <= thr_reg[i-1];
                                    msk_reg[i] <= msk_reg[i-1];
                                end
                                thr_reg[0] <= cq_cmd.thread_id[THREAD_ID_BITS-1:0];
                                msk_reg[0] <= cq_cmd.wait_mask;
                                n_reg <= n_reg + CW'(1);
                            end
                        end else if (cq_cmd.opcode > OP_CLAIM) begin
                            out_reg <= '{ST_WAKE, 1'b0, 8'd0, 5'd0, n_reg != '0, 1'b1};
                            ov_reg <= 1'b1;
                        end else begin
                            st_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!done_scan) begin
                        if (cur_hit && pc_reg == BW'(BATCH)) begin
                            st_reg <= S_EMIT;
                        end else begin
                            rd_reg <= rd_reg + CW'(1);
                            if (cur_hit) begin
                                pick_reg[pc_reg[PW-1:0]] <= cur_thr;
                                pc_reg <= pc_reg + BW'(1);
                                m_reg <= m_reg + CW'(1);
                            end else begin
                                thr_reg[wr_reg[IW-1:0]] <= cur_thr;
                                msk_reg[wr_reg[IW-1:0]] <= cur_msk;
                                wr_reg <= wr_reg + CW'(1);
                            end
                        end
                    end else if (pc_reg != '0) begin
                        st_reg <= S_EMIT;
                    end else begin
                        if (rd_reg < n0_reg) begin
                            thr_reg[wr_reg[IW-1:0]] <= cur_thr;
                            msk_reg[wr_reg[IW-1:0]] <= cur_msk;
                            wr_reg <= wr_reg + CW'(1);
                            rd_reg <= rd_reg + CW'(1);
                        end else begin
                            n_reg <= wr_reg;
                            if (m_reg == '0) begin
                                if (out_free) begin
                                    out_reg <= '{ST_WAKE, 1'b0, 8'd0, 5'd0,
                                                 n0_reg != '0, 1'b1};
                                    ov_reg <= 1'b1;
                                    st_reg <= S_IDLE;
                                end
                            end else begin
                                st_reg <= S_IDLE;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_reg.status <= ST_WAKE;
                        out_reg.woke_valid <= 1'b1;
                        out_reg.woken_thread <= 8'(pick_reg[pc_dec[PW-1:0]]);
                        out_reg.wake_cnt <= 5'(cnt_inc);
                        out_reg.queue_nonempty <= (n0_reg - cnt_inc) != '0;
                        out_reg.last_result <= last_batch && (pc_reg == BW'(1));
                        ov_reg <= 1'b1;
                        cnt_reg <= cnt_inc;
                        pc_reg <= pc_dec;
                        if (pc_reg == BW'(1)) st_reg <= S_SCAN;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/wait_queue_signal_match.sv
// Top level of the wait queue block: command queue front end and table back end.
// Depends on wqsm_pkg, wqsm_front and wqsm_back.
//
// One item is handled at a time by the back end. A park or an unknown opcode goes
// from the command queue into the result register when the back end accepts it,
// with no scan of the table. A wake or claim is accepted, scans every occupied
// slot, emits one result per woken thread in batches of up to BATCH woken threads
// and finishes by updating the occupancy. The slot scan and the emission set the
// rate. A two-entry queue takes transfers while the back end works; the result
// register holds one result, and a stalled result stalls the back end.
`default_nettype none
module wait_queue_signal_match #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int BATCH          = 8
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // opcode[2:0], thread_id[10:3], wait_mask[42:11], signal_bits[74:43],
    // thread_killed[75], predicate_holds[76], zero pad
    input  wire  [79:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status[2:0], woke_valid[3], woken_thread[11:4], wake count[16:12],
    // queue_nonempty[17], zero pad
    output logic [23:0]  m_tdata,
    output logic         m_tlast
);
    import wqsm_pkg::*;
    cmd_t in_cmd, cq_cmd;
    res_t res;
    logic cq_valid, cq_ready;

    assign in_cmd = '{s_tdata[2:0], s_tdata[10:3], s_tdata[42:11], s_tdata[74:43],
                      s_tdata[75], s_tdata[76]};

    wqsm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .cq_valid(cq_valid), .cq_ready(cq_ready), .cq_cmd(cq_cmd)
    );

    wqsm_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH), .BATCH(BATCH)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cq_valid(cq_valid), .cq_ready(cq_ready), .cq_cmd(cq_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
    );

    assign m_tdata = {6'd0, res.queue_nonempty, res.wake_cnt, res.woken_thread,
                      res.woke_valid, res.status};
    assign m_tlast = res.last_result;
endmodule
`default_nettype wire

>>> rtl/core/wqsm_checker.sv
// Port checker for the wait queue block, bound to the top level.
// Depends on wqsm_pkg and wait_queue_signal_match_macros.svh.
`default_nettype none
`include "wait_queue_signal_match_macros.svh"
module wqsm_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        m_tlast
);
    import wqsm_pkg::*;
    logic [2:0] st;
    logic       woke;

    assign st   = m_tdata[2:0];
    assign woke = m_tdata[3];

    `WQSM_ASSERT_IMPL(a_park_plain, aclk, aresetn, m_tvalid && st != ST_WAKE, !woke && m_tlast)
    `WQSM_ASSERT_IMPL(a_id_zero, aclk, aresetn, m_tvalid && !woke, m_tdata[16:4] == 13'd0)
    `WQSM_ASSERT_IMPL(a_pad, aclk, aresetn, m_tvalid, m_tdata[23:18] == 6'd0)
    `WQSM_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind wait_queue_signal_match wqsm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

>>> sim/testbench.sv
// Testbench for wait_queue_signal_match: random and directed park, wake and claim
// transfers checked against an in-bench model of the waiter table.
// Depends on wqsm_pkg and the wait_queue_signal_match RTL.
`default_nettype none

class wait_table_board;
    localparam int DEPTH = 16;
    localparam int GROUP = 8;

    bit [7:0]  tids[$];
    bit [31:0] masks[$];
    bit [23:0] exp_data[$];
    bit        exp_last[$];
    int        errors;

    function void push_res(bit [2:0] st, bit vld, bit [7:0] tid, bit [4:0] cnt,
                           bit nonempty, bit last);
        exp_data.insert(exp_data.size(), {6'd0, nonempty, cnt, tid, vld, st});
        exp_last.insert(exp_last.size(), last);
    endfunction

    function int depth_now();
        return tids.size();
    endfunction

    function void note_cmd(wqsm_pkg::cmd_t c);
        bit [7:0]  picked[$];
        bit [7:0]  kt[$];
        bit [31:0] km[$];
        bit        hit;
        int        n, cnt, stop;
        n = tids.size();
        case (c.opcode)
            wqsm_pkg::OP_PARK: begin
                if (c.wait_mask != 0 && c.thread_killed)
                    push_res(wqsm_pkg::ST_KILLED, 0, 0, 0, n != 0, 1);
                else if (!c.predicate_holds)
                    push_res(wqsm_pkg::ST_PRED, 0, 0, 0, n != 0, 1);
                else if (n >= DEPTH)
                    push_res(wqsm_pkg::ST_FULL, 0, 0, 0, n != 0, 1);
                else begin
                    tids.push_front(c.thread_id);
                    masks.push_front(c.wait_mask);
                    push_res(wqsm_pkg::ST_PARKED, 0, 0, 0, 1, 1);
                end
            end
            wqsm_pkg::OP_WAKE_ONE, wqsm_pkg::OP_CLAIM: begin
                for (int i = 0; i < n; i++) begin
                    hit = (c.opcode == wqsm_pkg::OP_WAKE_ONE) ? masks[i] == 0
                                                              : tids[i] == c.thread_id;
                    if (hit) begin
                        push_res(wqsm_pkg::ST_WAKE, 1, tids[i], 1, n > 1, 1);
                        tids.delete(i);
                        masks.delete(i);
                        return;
                    end
                end
                push_res(wqsm_pkg::ST_WAKE, 0, 0, 0, n != 0, 1);
            end
            wqsm_pkg::OP_WAKE_ALL, wqsm_pkg::OP_WAKE_MTCH: begin
                for (int i = 0; i < n; i++) begin
                    hit = (c.opcode == wqsm_pkg::OP_WAKE_ALL) ? masks[i] == 0
                          : (masks[i] & c.signal_bits) != 0;
                    if (hit) picked.insert(picked.size(), tids[i]);
                    else begin
                        kt.insert(kt.size(), tids[i]);
                        km.insert(km.size(), masks[i]);
                    end
                end
                tids = kt;
                masks = km;
                if (picked.size() == 0) begin
                    push_res(wqsm_pkg::ST_WAKE, 0, 0, 0, n != 0, 1);
                    return;
                end
                cnt = 0;
                for (int b = 0; b < picked.size(); b += GROUP) begin
                    stop = (b + GROUP < picked.size()) ? b + GROUP : picked.size();
                    for (int k = stop; k > b; k--) begin
                        cnt++;
                        push_res(wqsm_pkg::ST_WAKE, 1, picked[k-1], 5'(cnt), n != cnt,
                                 cnt == picked.size());
                    end
                end
            end
            default: push_res(wqsm_pkg::ST_WAKE, 0, 0, 0, n != 0, 1);
        endcase
    endfunction

    function void check_res(bit [23:0] d, bit last);
        bit [23:0] ed;
        bit        el;
        if (exp_data.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h last %b",
                     $time, d, last);
            errors++;
            return;
        end
        ed = exp_data.pop_front();
        el = exp_last.pop_front();
        if (d[2:0] != ed[2:0] || d[3] != ed[3] || d[11:4] != ed[11:4]
            || d[16:12] != ed[16:12] || d[17] != ed[17] || last != el) begin
            $display("%0t: mismatch, expected %h last %b, actual %h last %b",
                     $time, ed, el, d, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    wait_table_board board = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    longint cycles = 0;

    wait_queue_signal_match u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) board.check_res(m_tdata, m_tlast);
    end

    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall);

    task automatic send(wqsm_pkg::cmd_t c);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'd0, c.predicate_holds, c.thread_killed, c.signal_bits,
                    c.wait_mask, c.thread_id, c.opcode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_cmd(c);
        @(negedge aclk);
    endtask

    function automatic wqsm_pkg::cmd_t mk(logic [2:0] op, logic [7:0] tid,
                                          logic [31:0] m, logic [31:0] sig,
                                          logic k, logic p);
        wqsm_pkg::cmd_t c;
        c.opcode = op; c.thread_id = tid; c.wait_mask = m;
        c.signal_bits = sig; c.thread_killed = k; c.predicate_holds = p;
        return c;
    endfunction

    function automatic logic [31:0] rnd_mask();
        case ($urandom_range(3))
            0: return 0;
            1: return 32'd1 << $urandom_range(31);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        wqsm_pkg::cmd_t c;
        int r;
        r = $urandom_range(99);
        c = mk(0, 8'($urandom_range(255)), rnd_mask(), rnd_mask(),
               $urandom_range(9) == 0, $urandom_range(9) != 0);
        if (r < 50) c.opcode = wqsm_pkg::OP_PARK;
        else if (r < 62) c.opcode = wqsm_pkg::OP_WAKE_ONE;
        else if (r < 70) c.opcode = wqsm_pkg::OP_WAKE_ALL;
        else if (r < 82) c.opcode = wqsm_pkg::OP_WAKE_MTCH;
        else if (r < 96) c.opcode = wqsm_pkg::OP_CLAIM;
        else c.opcode = 3'($urandom_range(7, 5));
        if (c.opcode == wqsm_pkg::OP_CLAIM && board.depth_now() > 0
            && $urandom_range(3) != 0)
            c.thread_id = board.tids[$urandom_range(board.depth_now() - 1)];
        send(c);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send(mk(wqsm_pkg::OP_WAKE_ONE, 0, 0, 0, 0, 1));
        send(mk(wqsm_pkg::OP_WAKE_ALL, 0, 0, 0, 0, 1));
        send(mk(wqsm_pkg::OP_WAKE_MTCH, 0, 0, '1, 0, 1));
        send(mk(wqsm_pkg::OP_CLAIM, 8'hFF, 0, 0, 0, 1));
        send(mk(wqsm_pkg::OP_PARK, 1, 32'h1, 0, 1, 1));
        send(mk(wqsm_pkg::OP_PARK, 2, 0, 0, 1, 0));
        send(mk(wqsm_pkg::OP_PARK, 3, 32'h1, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            send(mk(wqsm_pkg::OP_PARK, 8'(i * 15), (i % 3 == 0) ? 32'h0
                    : (32'h8000_0001 << (i % 2)), '1, 0, 1));
        send(mk(wqsm_pkg::OP_WAKE_ONE, 0, 0, 0, 0, 1));
        send(mk(wqsm_pkg::OP_WAKE_MTCH, 0, 0, '1, 0, 1));
        send(mk(wqsm_pkg::OP_CLAIM, 8'd45, 0, 0, 0, 1));
        send(mk(3'd7, 0, 0, 0, 0, 1));
        send(mk(wqsm_pkg::OP_WAKE_ALL, 0, 0, 0, 0, 1));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 51) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 51) : 0;
            for (int i = 0; i < 125; i++) random_item();
        end
        s_tvalid <= 0;
        recv_stall = 0;

        while (board.exp_data.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/wqsm_pkg.sv
rtl/core/wqsm_front.sv
rtl/core/wqsm_back.sv
rtl/core/wait_queue_signal_match.sv
rtl/core/wqsm_checker.sv
sim/testbench.sv
